### sv/llcb_pkg.sv
// ----------------------------------------------------------------------------
// llcb_pkg
// Types and constants shared by the last-lines capture buffer modules:
// request and response payloads, command codes and the controller to
// datapath command and status groups.
// ----------------------------------------------------------------------------
package llcb_pkg;

   // request command codes
   localparam logic [1:0] CMD_DATA = 2'd0;
   localparam logic [1:0] CMD_END  = 2'd1;
   localparam logic [1:0] CMD_READ = 2'd2;

   // line terminator
   localparam logic [7:0] NEWLINE = 8'd10;

   // lines_kept after reset
   localparam logic [6:0] LINES_KEPT_RESET = 7'd10;

   typedef struct packed {
      logic [1:0] command;
      logic [7:0] data_byte;
   } llcb_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       valid_res;
      logic       last;
   } llcb_rsp_type;

   // controller to datapath
   typedef struct packed {
      logic clear;       // drop the stored stream before this item
      logic write_byte;  // store a content byte into the open line
      logic commit;      // terminate the open line with a newline
      logic end_mark;    // mark end of stream, rewind the read pointer
      logic finish;      // consume the byte fetched for a read
      logic hit;         // the current response carries data
   } llcb_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic ended;
      logic part_full;
      logic part_nonempty;
      logic read_avail;
   } llcb_stat_type;

endpackage

### sv/llcb_ctrl.sv
// ----------------------------------------------------------------------------
// llcb_ctrl
// Command decoder and state machine. Data and end transfers finish in the
// cycle they are taken; a read then waits in the response state for the
// registered memory data.
// ----------------------------------------------------------------------------
module llcb_ctrl
   import llcb_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          start,
   input  llcb_req_type  req_data,
   input  llcb_stat_type stat,
   output logic          busy,
   output logic          rsp_valid,
   output llcb_cmd_type  cmd
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RESP = 1'b1;

   logic state_ff, state_in;
   logic hit_ff, hit_in;
   logic accept;
   logic is_newline;

   assign accept     = start && (state_ff == ST_IDLE);
   assign is_newline = (req_data.data_byte == NEWLINE);

   // decode
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      hit_in   = hit_ff;
      if (state_ff == ST_RESP) begin
         cmd.hit    = hit_ff;
         cmd.finish = hit_ff;
         state_in   = ST_IDLE;
      end else if (accept) begin
         case (req_data.command)
            CMD_DATA: begin
               cmd.clear      = stat.ended;
               cmd.commit     = is_newline;
               cmd.write_byte = !is_newline && (stat.ended || !stat.part_full);
            end
            CMD_END: begin
               cmd.commit   = !stat.ended && stat.part_nonempty;
               cmd.end_mark = !stat.ended;
            end
            CMD_READ: begin
               hit_in   = stat.ended && stat.read_avail;
               state_in = ST_RESP;
            end
            default: begin
            end
         endcase
      end
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         hit_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         hit_ff   <= hit_in;
      end
   end

   assign busy      = (state_ff == ST_RESP);
   assign rsp_valid = (state_ff == ST_RESP);

endmodule

### sv/llcb_dpath.sv
// ----------------------------------------------------------------------------
// llcb_dpath
// Line ring storage and pointers. Content bytes go straight into the slot
// that the open line will occupy; a commit writes the newline and the line
// length. Slot numbers and slot base addresses advance incrementally.
// ----------------------------------------------------------------------------
module llcb_dpath
   import llcb_pkg::*;
#(
   parameter int LINE_SLOTS = 64,
   parameter int LINE_BYTES = 256
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [6:0]    csr_wdata,
   input  logic [7:0]    data_byte,
   input  llcb_cmd_type  cmd,
   output llcb_stat_type stat,
   output llcb_rsp_type  rsp_data
);

   localparam int DEPTH = LINE_SLOTS * LINE_BYTES;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = (LINE_SLOTS > 1) ? $clog2(LINE_SLOTS) : 1;
   localparam int CW    = $clog2(LINE_SLOTS + 1);
   localparam int LW    = $clog2(LINE_BYTES);
   localparam int LLW   = $clog2(LINE_BYTES + 1);

   localparam logic [AW-1:0] SLOT_STRIDE = AW'(LINE_BYTES);
   localparam logic [LW-1:0] CONTENT_MAX = LW'(LINE_BYTES - 1);
   localparam logic [CW-1:0] CAP_RESET   = (int'(LINES_KEPT_RESET) > LINE_SLOTS) ?
                                           CW'(LINE_SLOTS) : CW'(LINES_KEPT_RESET);

   // storage
   logic [7:0]     store_mem [DEPTH];
   logic [LLW-1:0] len_mem   [LINE_SLOTS];

   logic [CW-1:0]  cap_ff, cap_in;
   logic [LW-1:0]  part_len_ff, part_len_in;
   logic [SW-1:0]  wr_slot_ff, wr_slot_in;
   logic [AW-1:0]  wr_base_ff, wr_base_in;
   logic [SW-1:0]  old_slot_ff, old_slot_in;
   logic [AW-1:0]  old_base_ff, old_base_in;
   logic [CW-1:0]  count_ff, count_in;
   logic [SW-1:0]  rd_slot_ff, rd_slot_in;
   logic [AW-1:0]  rd_base_ff, rd_base_in;
   logic [CW-1:0]  rd_line_ff, rd_line_in;
   logic [LW-1:0]  rd_ofs_ff, rd_ofs_in;
   logic           ended_ff, ended_in;
   logic [7:0]     rd_byte_ff;
   logic [LLW-1:0] rd_len_ff;

   logic           clear_all;
   logic [LW-1:0]  part_len_e;
   logic [SW-1:0]  wr_slot_e, old_slot_e;
   logic [AW-1:0]  wr_base_e, old_base_e;
   logic [CW-1:0]  count_e;
   logic [AW-1:0]  wr_addr;
   logic [7:0]     wr_byte;
   logic [LLW-1:0] commit_len;
   logic           wr_wrap, old_wrap, rd_wrap;
   logic [LLW-1:0] rd_ofs_p1;
   logic           line_done;
   logic [CW-1:0]  rd_line_p1;

   assign clear_all = cmd.clear || csr_we;

   // state as seen after an optional clear
   assign part_len_e = clear_all ? '0 : part_len_ff;
   assign wr_slot_e  = clear_all ? '0 : wr_slot_ff;
   assign wr_base_e  = clear_all ? '0 : wr_base_ff;
   assign old_slot_e = clear_all ? '0 : old_slot_ff;
   assign old_base_e = clear_all ? '0 : old_base_ff;
   assign count_e    = clear_all ? '0 : count_ff;

   // write port
   assign wr_addr    = wr_base_e + AW'(part_len_e);
   assign wr_byte    = cmd.commit ? NEWLINE : data_byte;
   assign commit_len = LLW'(part_len_e) + LLW'(1);

   assign wr_wrap  = (CW'(wr_slot_e) == cap_ff - CW'(1));
   assign old_wrap = (CW'(old_slot_e) == cap_ff - CW'(1));
   assign rd_wrap  = (CW'(rd_slot_ff) == cap_ff - CW'(1));

   // read advance
   assign rd_ofs_p1  = LLW'(rd_ofs_ff) + LLW'(1);
   assign line_done  = (rd_ofs_p1 >= rd_len_ff);
   assign rd_line_p1 = rd_line_ff + CW'(1);

   // next state
   always_comb begin
      cap_in      = cap_ff;
      part_len_in = part_len_e;
      wr_slot_in  = wr_slot_e;
      wr_base_in  = wr_base_e;
      old_slot_in = old_slot_e;
      old_base_in = old_base_e;
      count_in    = count_e;
      rd_slot_in  = rd_slot_ff;
      rd_base_in  = rd_base_ff;
      rd_line_in  = clear_all ? '0 : rd_line_ff;
      rd_ofs_in   = clear_all ? '0 : rd_ofs_ff;
      ended_in    = clear_all ? 1'b0 : ended_ff;

      if (csr_we) begin
         if (csr_wdata == 7'd0) begin
            cap_in = CW'(1);
         end else if (int'(csr_wdata) > LINE_SLOTS) begin
            cap_in = CW'(LINE_SLOTS);
         end else begin
            cap_in = CW'(csr_wdata);
         end
      end

      if (cmd.write_byte) begin
         part_len_in = part_len_e + LW'(1);
      end

      // commit: next slot, and the oldest line drops out once the ring is full
      if (cmd.commit) begin
         part_len_in = '0;
         wr_slot_in  = wr_wrap ? '0 : wr_slot_e + SW'(1);
         wr_base_in  = wr_wrap ? '0 : wr_base_e + SLOT_STRIDE;
         if (count_e < cap_ff) begin
            count_in = count_e + CW'(1);
         end else begin
            old_slot_in = old_wrap ? '0 : old_slot_e + SW'(1);
            old_base_in = old_wrap ? '0 : old_base_e + SLOT_STRIDE;
         end
      end

      // end of stream: rewind to the oldest line
      if (cmd.end_mark) begin
         ended_in   = 1'b1;
         rd_slot_in = old_slot_in;
         rd_base_in = old_base_in;
         rd_line_in = '0;
         rd_ofs_in  = '0;
      end

      if (cmd.finish) begin
         if (line_done) begin
            rd_ofs_in  = '0;
            rd_line_in = rd_line_p1;
            rd_slot_in = rd_wrap ? '0 : rd_slot_ff + SW'(1);
            rd_base_in = rd_wrap ? '0 : rd_base_ff + SLOT_STRIDE;
         end else begin
            rd_ofs_in = rd_ofs_ff + LW'(1);
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff      <= CAP_RESET;
         part_len_ff <= '0;
         wr_slot_ff  <= '0;
         wr_base_ff  <= '0;
         old_slot_ff <= '0;
         old_base_ff <= '0;
         count_ff    <= '0;
         rd_slot_ff  <= '0;
         rd_base_ff  <= '0;
         rd_line_ff  <= '0;
         rd_ofs_ff   <= '0;
         ended_ff    <= 1'b0;
      end else begin
         cap_ff      <= cap_in;
         part_len_ff <= part_len_in;
         wr_slot_ff  <= wr_slot_in;
         wr_base_ff  <= wr_base_in;
         old_slot_ff <= old_slot_in;
         old_base_ff <= old_base_in;
         count_ff    <= count_in;
         rd_slot_ff  <= rd_slot_in;
         rd_base_ff  <= rd_base_in;
         rd_line_ff  <= rd_line_in;
         rd_ofs_ff   <= rd_ofs_in;
         ended_ff    <= ended_in;
      end
   end

   // line byte memory
   always_ff @(posedge clock) begin
      if (cmd.write_byte || cmd.commit) begin
         store_mem[wr_addr] <= wr_byte;
      end
      rd_byte_ff <= store_mem[rd_base_ff + AW'(rd_ofs_ff)];
   end

   // line length memory
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         len_mem[wr_slot_e] <= commit_len;
      end
      rd_len_ff <= len_mem[rd_slot_ff];
   end

   // status
   assign stat.ended         = ended_ff;
   assign stat.part_full     = (part_len_ff == CONTENT_MAX);
   assign stat.part_nonempty = (part_len_ff != '0);
   assign stat.read_avail    = (rd_line_ff < count_ff);

   // response payload
   assign rsp_data.out_byte  = cmd.hit ? rd_byte_ff : 8'd0;
   assign rsp_data.valid_res = cmd.hit;
   assign rsp_data.last      = cmd.hit && line_done && (rd_line_p1 == count_ff);

endmodule

### sv/last_lines_capture_buffer.sv
// ----------------------------------------------------------------------------
// last_lines_capture_buffer
// Keeps the most recent lines of a byte stream in a ring of line slots and
// plays them back byte by byte, oldest line first.
// ----------------------------------------------------------------------------
// A data or end command completes in the cycle it is taken and busy stays
// low, so such commands can be issued every cycle while busy is low. After a
// read command, busy is high for one cycle while the line byte and line
// length memories deliver their registered read data, and the response strobe
// rsp_valid is high in that same cycle. The response is shown for that single
// cycle only; the receiver has no way to hold it, so it must capture rsp_data
// whenever rsp_valid is high. No clearing pass is run after reset. Write
// csr_wdata only while no read is in flight; a write clears the stored stream.
module last_lines_capture_buffer
   import llcb_pkg::*;
#(
   parameter int LINE_SLOTS = 64,
   parameter int LINE_BYTES = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  llcb_req_type req_data,
   output logic         rsp_valid,
   output llcb_rsp_type rsp_data,
   input  logic         csr_we,
   input  logic [6:0]   csr_wdata
);

   llcb_cmd_type  cmd;
   llcb_stat_type stat;

   // controller
   llcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_data  (req_data),
      .stat      (stat),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd)
   );

   // datapath
   llcb_dpath #(
      .LINE_SLOTS (LINE_SLOTS),
      .LINE_BYTES (LINE_BYTES)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .data_byte (req_data.data_byte),
      .cmd       (cmd),
      .stat      (stat),
      .rsp_data  (rsp_data)
   );

`ifndef ASSERT_OFF
   // every accepted read gets its response in the next cycle
   a_read_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command == CMD_READ) |=> rsp_valid)
      else $error("read transfer without response");

   // data and end transfers produce no response
   a_no_rsp: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_data.command != CMD_READ) |=> !rsp_valid)
      else $error("response without read transfer");

   // last only on a response that carries data
   a_last_valid: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.last) |-> rsp_data.valid_res)
      else $error("last flag on empty response");

   // an empty response carries a zero byte
   a_empty_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_data.valid_res) |-> (rsp_data.out_byte == 8'd0))
      else $error("empty response with nonzero byte");
`endif

endmodule

### dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for last_lines_capture_buffer. A short table of
// commands with hand-read responses opens the run. Random streams of lines
// follow, most ended and then played back, under several ring sizes. Every
// response strobe is checked against its pinned value or the bench's line-ring predictor.
// ----------------------------------------------------------------------------
module tb_top;
   import llcb_pkg::*;

   localparam int SLOTS         = 64;
   localparam int SLOT_BYTES    = 256;
   localparam int CONTENT_MAX   = SLOT_BYTES - 1;
   localparam int ITEM_TARGET   = 1150;
   localparam int QUIET_TAIL    = 150;
   localparam int CYCLE_LIMIT   = 400000;
   localparam int SETTLE_CYCLES = 4;
   localparam int REPORT_MAX    = 10;
   localparam logic [1:0] CMD_SPARE = 2'd3;

   typedef struct packed {
      logic [1:0]   cmd;
      logic [7:0]   value;
      logic         pinned;
      llcb_rsp_type rsp;
   } step_row_type;

   logic         clock = 1'b0;
   logic         reset;
   logic         start;
   logic         busy;
   llcb_req_type req_data;
   logic         rsp_valid;
   llcb_rsp_type rsp_data;
   logic         csr_we;
   logic [6:0]   csr_wdata;

   // line-ring predictor state
   logic [7:0]  ring_mem [SLOTS][SLOT_BYTES];
   int unsigned ring_len [SLOTS];
   logic [7:0]  open_line [CONTENT_MAX];
   int unsigned open_len;
   int unsigned head_slot;
   int unsigned line_total;
   int unsigned play_line;
   int unsigned play_off;
   bit          stream_done;
   logic [6:0]  keep_cfg;

   llcb_rsp_type playback_q [$];
   int unsigned  mismatch_count = 0;
   int unsigned  sent_items = 0;
   int unsigned  gap_pct = 0;
   int unsigned  cycle_count = 0;

   logic [6:0] keep_plan [5] = '{7'd1, 7'd64, 7'd0, 7'd127, 7'd2};

   // opening commands; pinned rows carry the response read off by hand
   step_row_type steps [23] = '{
      '{CMD_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_DATA,  8'h41, 1'b0, '0},
      '{CMD_DATA,  8'h00, 1'b0, '0},
      '{CMD_DATA,  8'hFF, 1'b0, '0},
      '{CMD_DATA,  8'h0A, 1'b0, '0},
      '{CMD_SPARE, 8'hAA, 1'b0, '0},
      '{CMD_DATA,  8'h55, 1'b0, '0},
      '{CMD_END,   8'h00, 1'b0, '0},
      '{CMD_END,   8'hFF, 1'b0, '0},
      '{CMD_READ,  8'h00, 1'b1, '{8'h41, 1'b1, 1'b0}},
      '{CMD_READ,  8'hFF, 1'b1, '{8'h00, 1'b1, 1'b0}},
      '{CMD_READ,  8'h00, 1'b1, '{8'hFF, 1'b1, 1'b0}},
      '{CMD_READ,  8'h00, 1'b1, '{8'h0A, 1'b1, 1'b0}},
      '{CMD_READ,  8'h00, 1'b1, '{8'h55, 1'b1, 1'b0}},
      '{CMD_READ,  8'h00, 1'b1, '{8'h0A, 1'b1, 1'b1}},
      '{CMD_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_DATA,  8'h0A, 1'b0, '0},
      '{CMD_END,   8'h00, 1'b0, '0},
      '{CMD_READ,  8'h00, 1'b1, '{8'h0A, 1'b1, 1'b1}},
      '{CMD_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}},
      '{CMD_END,   8'h00, 1'b0, '0},
      '{CMD_DATA,  8'h7F, 1'b0, '0},
      '{CMD_READ,  8'h00, 1'b1, '{8'h00, 1'b0, 1'b0}}
   };

   last_lines_capture_buffer uut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   // ring size in use: register held within 1..SLOTS
   function automatic int unsigned ring_size();
      int unsigned k;
      k = {25'd0, keep_cfg};
      if (k < 1) k = 1;
      if (k > SLOTS) k = SLOTS;
      return k;
   endfunction

   function automatic void drop_stream();
      open_len    = 0;
      head_slot   = 0;
      line_total  = 0;
      play_line   = 0;
      play_off    = 0;
      stream_done = 1'b0;
   endfunction

   // move the open line into the next slot, overwriting the oldest when full
   function automatic void close_line();
      int unsigned k;
      int unsigned slot;
      int unsigned n;
      int unsigned i;
      k = ring_size();
      slot = (head_slot + line_total) % k;
      n = (open_len > CONTENT_MAX) ? CONTENT_MAX : open_len;
      for (i = 0; i < n; i++) ring_mem[slot][i] = open_line[i];
      ring_mem[slot][n] = NEWLINE;
      ring_len[slot] = n + 1;
      if (line_total < k) line_total++;
      else head_slot = (head_slot + 1) % k;
      open_len = 0;
   endfunction

   // advance the ring by one command; returns 1 when a response is due
   function automatic bit tail_step(input llcb_req_type item, output llcb_rsp_type rsp);
      int unsigned slot;
      rsp = '0;
      case (item.command)
         CMD_DATA: begin
            if (stream_done) drop_stream();
            if (item.data_byte == NEWLINE) begin
               close_line();
            end else if (open_len < CONTENT_MAX) begin
               open_line[open_len] = item.data_byte;
               open_len++;
            end
            return 1'b0;
         end
         CMD_END: begin
            if (!stream_done) begin
               if (open_len > 0) close_line();
               stream_done = 1'b1;
               play_line = 0;
               play_off = 0;
            end
            return 1'b0;
         end
         CMD_READ: begin
            if (stream_done && play_line < line_total) begin
               slot = (head_slot + play_line) % ring_size();
               if (play_off >= SLOT_BYTES) play_off = SLOT_BYTES - 1;
               rsp.out_byte = ring_mem[slot][play_off];
               rsp.valid_res = 1'b1;
               play_off++;
               if (play_off >= ring_len[slot]) begin
                  play_off = 0;
                  play_line++;
                  rsp.last = (play_line >= line_total);
               end
            end
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic llcb_req_type make_req(input logic [1:0] cmd, input logic [7:0] value);
      llcb_req_type item;
      item.command = cmd;
      item.data_byte = value;
      return item;
   endfunction

   function automatic void note_mismatch(input string msg);
      if (mismatch_count < REPORT_MAX) $display("mismatch at %0t: %s", $realtime, msg);
      mismatch_count++;
   endfunction

   task automatic pause_sender(input int unsigned cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // one transfer on the request side, then maybe a gap
   task automatic send_item(input llcb_req_type item, input bit pinned = 1'b0,
                            input llcb_rsp_type pinned_rsp = '0);
      llcb_rsp_type predicted;
      start <= 1'b1;
      req_data <= item;
      do @(posedge clock); while (busy);
      if (tail_step(item, predicted)) playback_q.push_back(pinned ? pinned_rsp : predicted);
      if (item.command != CMD_SPARE) sent_items++;
      if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) pause_sender($urandom_range(1, 8));
   endtask

   // random line content with the odd stray command mixed in
   task automatic send_content();
      if ($urandom_range(0, 19) == 0)
         send_item(make_req(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255))));
      send_item(make_req(CMD_DATA, 8'($urandom_range(0, 255))));
   endtask

   task automatic drain_results();
      start <= 1'b0;
      while (playback_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_keep(input logic [6:0] value);
      drain_results();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      keep_cfg = value;
      drop_stream();
   endtask

   // response checker: the receiver takes every strobe
   always @(posedge clock) begin
      llcb_rsp_type want;
      if (!reset && rsp_valid) begin
         if (playback_q.size() == 0) begin
            note_mismatch($sformatf("unexpected response %h", rsp_data));
         end else begin
            want = playback_q.pop_front();
            if (rsp_data.out_byte !== want.out_byte || rsp_data.valid_res !== want.valid_res ||
                rsp_data.last !== want.last)
               note_mismatch($sformatf("byte %h valid %b last %b, expected %h %b %b",
                  rsp_data.out_byte, rsp_data.valid_res, rsp_data.last,
                  want.out_byte, want.valid_res, want.last));
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      int unsigned phase;
      int unsigned line_goal;
      int unsigned line_bytes;
      int unsigned ln;
      int unsigned read_cap;
      int unsigned reads_done;
      bit          bulk;

      reset <= 1'b1;
      start <= 1'b0;
      req_data <= '0;
      csr_we <= 1'b0;
      csr_wdata <= '0;
      keep_cfg = LINES_KEPT_RESET;
      drop_stream();
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (steps[i])
         send_item(make_req(steps[i].cmd, steps[i].value), steps[i].pinned, steps[i].rsp);

      // random streams, one ring setting per phase
      phase = 0;
      while (sent_items < ITEM_TARGET) begin
         if (phase < 5) write_keep(keep_plan[phase]);
         else if ($urandom_range(0, 3) == 0) write_keep(7'($urandom_range(0, 127)));

         case ($urandom_range(0, 2))
            0: gap_pct = 0;
            1: gap_pct = 15;
            default: gap_pct = 40;
         endcase
         if (sent_items + QUIET_TAIL > ITEM_TARGET) gap_pct = 0;

         // full ring at the largest size wraps past its oldest line
         bulk = (phase == 1);
         if (bulk) line_goal = ring_size() + 2;
         else line_goal = $urandom_range(0, (ring_size() < 6) ? ring_size() + 3 : 6);

         for (ln = 0; ln < line_goal; ln++) begin
            if (bulk) line_bytes = $urandom_range(0, 2);
            else if ((phase == 2 && ln == 0) || $urandom_range(0, 29) == 0)
               line_bytes = $urandom_range(250, 300);
            else line_bytes = $urandom_range(0, 12);
            repeat (line_bytes) send_content();
            send_item(make_req(CMD_DATA, NEWLINE));
         end

         // unterminated final line, committed by the end command
         if ($urandom_range(0, 1) == 0) repeat ($urandom_range(1, 5)) send_content();
         if ($urandom_range(0, 9) != 0)
            send_item(make_req(CMD_END, 8'($urandom_range(0, 255))));
         if ($urandom_range(0, 7) == 0)
            send_item(make_req(CMD_END, 8'($urandom_range(0, 255))));

         // play back, now and then cut short so the next data lands mid-read
         read_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 20) : 32'hFFFF_FFFF;
         reads_done = 0;
         while (stream_done && play_line < line_total && reads_done < read_cap) begin
            send_item(make_req(CMD_READ, 8'($urandom_range(0, 255))));
            reads_done++;
         end
         repeat ($urandom_range(0, 2))
            send_item(make_req(CMD_READ, 8'($urandom_range(0, 255))));

         // sender holds off until the response side has caught up
         if (phase == 6) drain_results();
         phase++;
      end

      drain_results();
      if (mismatch_count == 0 && playback_q.size() == 0) $display("end of test: clean");
      else $display("end of test: mismatches");
      $finish;
   end

endmodule

### files.f
sv/llcb_pkg.sv
sv/llcb_ctrl.sv
sv/llcb_dpath.sv
sv/last_lines_capture_buffer.sv
dv/tb_top.sv
